// ===== design/fw2d_pkg.sv =====
package fw2d_pkg;

   localparam int DEF_ROWS = 64;
   localparam int DEF_COLS = 64;
   localparam int COORD_W  = 7;
   localparam int DATA_W   = 32;

   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic [COORD_W-1:0]       top_row;
      logic [COORD_W-1:0]       left_col;
      logic [COORD_W-1:0]       bottom_row;
      logic [COORD_W-1:0]       right_col;
      logic signed [DATA_W-1:0] add_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] rect_sum;
      logic                     bad_request;
   } rsp_payload_type;

endpackage

// ===== design/fenwick_tree_2d_rect_sum.sv =====
// add: a read and a write per touched cell, (log2 ROWS + 1) * (log2 COLS + 1) cells at most
// query: four prefix walks of one tree read per step, one step per empty walk, a drain step,
// then ST_DONE until the output register takes the result, one transaction at a time
// a bad request skips the tree and goes straight to ST_DONE
// reset: synchronous, clears control, then zeroes the tree one entry per cycle, all
// 2^(clog2 ROWS + clog2 COLS) entries (4096 at 64x64), while req_stall stays high
module fenwick_tree_2d_rect_sum #(
   parameter int ROWS = fw2d_pkg::DEF_ROWS,
   parameter int COLS = fw2d_pkg::DEF_COLS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  fw2d_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output fw2d_pkg::rsp_payload_type rsp_data
);

   // tree address is {row - 1, col - 1}, each packed to a power of two
   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int AW = RW + CW;

   logic                        res_valid;
   logic                        res_take;
   fw2d_pkg::rsp_payload_type   res_data;
   logic                        ram_we;
   logic [AW-1:0]               ram_addr;
   logic [fw2d_pkg::DATA_W-1:0] ram_wdata;
   logic [fw2d_pkg::DATA_W-1:0] ram_rdata;

   logic                      rsp_valid_ff, rsp_valid_in;
   fw2d_pkg::rsp_payload_type rsp_data_ff,  rsp_data_in;

   // sequencer: clearing pass, point add walk, four prefix walks
   fw2d_ctrl #(
      .ROWS (ROWS),
      .COLS (COLS),
      .AW   (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   // fenwick partial sums, one read-or-write port
   fw2d_ram #(
      .WIDTH (fw2d_pkg::DATA_W),
      .DEPTH (1 << AW)
   ) u_tree (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // output register: a finished result moves in when the slot is free or draining
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/fw2d_ram.sv =====
module fw2d_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/fw2d_ctrl.sv =====
module fw2d_ctrl #(
   parameter int ROWS = fw2d_pkg::DEF_ROWS,
   parameter int COLS = fw2d_pkg::DEF_COLS,
   parameter int AW   = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fw2d_pkg::req_payload_type   req_data,
   output logic                        res_valid,
   input  logic                        res_take,
   output fw2d_pkg::rsp_payload_type   res_data,
   output logic                        ram_we,
   output logic [AW-1:0]               ram_addr,
   output logic [fw2d_pkg::DATA_W-1:0] ram_wdata,
   input  logic [fw2d_pkg::DATA_W-1:0] ram_rdata
);

   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW   = AW - RW;
   localparam int RIW0 = $clog2(ROWS + 1) + 1;
   localparam int CIW0 = $clog2(COLS + 1) + 1;
   localparam int RIW  = (RIW0 > fw2d_pkg::COORD_W) ? RIW0 : fw2d_pkg::COORD_W;
   localparam int CIW  = (CIW0 > fw2d_pkg::COORD_W) ? CIW0 : fw2d_pkg::COORD_W;
   localparam int DW   = fw2d_pkg::DATA_W;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_ADD_RD  = 3'd2;
   localparam logic [2:0] ST_ADD_WR  = 3'd3;
   localparam logic [2:0] ST_Q_WALK  = 3'd4;
   localparam logic [2:0] ST_Q_DRAIN = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   localparam logic [1:0] PH_BR    = 2'd0;
   localparam logic [1:0] PH_ABOVE = 2'd1;
   localparam logic [1:0] PH_LEFT  = 2'd2;
   localparam logic [1:0] PH_LAST  = 2'd3;

   logic [2:0]    state_ff,  state_in;
   logic [AW-1:0] clr_ff,    clr_in;
   logic [RIW-1:0] i_ff,     i_in;
   logic [CIW-1:0] j_ff,     j_in;
   logic [CIW-1:0] cbase_ff, cbase_in;
   logic [RIW-1:0] r1m1_ff,  r1m1_in;
   logic [RIW-1:0] r2_ff,    r2_in;
   logic [CIW-1:0] c1m1_ff,  c1m1_in;
   logic [CIW-1:0] c2_ff,    c2_in;
   logic [DW-1:0] val_ff,    val_in;
   logic [DW-1:0] acc_ff,    acc_in;
   logic [1:0]    phase_ff,  phase_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_neg_ff,  rd_neg_in;
   logic          bad_ff,     bad_in;

   logic [RIW-1:0] top_w, bot_w, i_low, i_up, i_dn, i_m1;
   logic [CIW-1:0] left_w, right_w, j_low, j_up, j_dn, j_m1;
   logic           add_ok, query_ok;
   logic [1:0]     ph_next;
   logic [RIW-1:0] ph_r;
   logic [CIW-1:0] ph_c;
   logic [DW-1:0]  rd_term;

   // coordinate extension and range checks
   assign top_w   = RIW'(req_data.top_row);
   assign bot_w   = RIW'(req_data.bottom_row);
   assign left_w  = CIW'(req_data.left_col);
   assign right_w = CIW'(req_data.right_col);

   assign add_ok = (top_w != '0) && (top_w <= RIW'(ROWS))
                && (left_w != '0) && (left_w <= CIW'(COLS));
   assign query_ok = add_ok && (bot_w != '0) && (bot_w <= RIW'(ROWS))
                  && (right_w != '0) && (right_w <= CIW'(COLS))
                  && (top_w <= bot_w) && (left_w <= right_w);

   // fenwick index steps
   assign i_low = i_ff & (~i_ff + RIW'(1));
   assign j_low = j_ff & (~j_ff + CIW'(1));
   assign i_up  = i_ff + i_low;
   assign j_up  = j_ff + j_low;
   assign i_dn  = i_ff - i_low;
   assign j_dn  = j_ff - j_low;
   assign i_m1  = i_ff - RIW'(1);
   assign j_m1  = j_ff - CIW'(1);

   // corner of the next prefix phase
   assign ph_next = phase_ff + 2'd1;
   always_comb begin
      unique case (ph_next)
         PH_BR: begin    ph_r = r2_ff;   ph_c = c2_ff;   end
         PH_ABOVE: begin ph_r = r1m1_ff; ph_c = c2_ff;   end
         PH_LEFT: begin  ph_r = r2_ff;   ph_c = c1m1_ff; end
         default: begin  ph_r = r1m1_ff; ph_c = c1m1_ff; end
      endcase
   end

   assign rd_term = rd_neg_ff ? (DW'(0) - ram_rdata) : ram_rdata;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      cbase_in   = cbase_ff;
      r1m1_in    = r1m1_ff;
      r2_in      = r2_ff;
      c1m1_in    = c1m1_ff;
      c2_in      = c2_ff;
      val_in     = val_ff;
      phase_in   = phase_ff;
      bad_in     = bad_ff;
      rd_pend_in = 1'b0;
      rd_neg_in  = 1'b0;
      acc_in     = rd_pend_ff ? (acc_ff + rd_term) : acc_ff;
      ram_we     = 1'b0;
      ram_wdata  = ram_rdata + val_ff;
      ram_addr   = {i_m1[RW-1:0], j_m1[CW-1:0]};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = '0;
            ram_addr  = clr_ff;
            clr_in    = clr_ff + AW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               acc_in   = '0;
               val_in   = req_data.add_value;
               phase_in = PH_BR;
               r1m1_in  = top_w - RIW'(1);
               r2_in    = bot_w;
               c1m1_in  = left_w - CIW'(1);
               c2_in    = right_w;
               if (req_data.req_type == fw2d_pkg::REQ_ADD) begin
                  i_in     = top_w;
                  j_in     = left_w;
                  cbase_in = left_w;
                  bad_in   = !add_ok;
                  state_in = add_ok ? ST_ADD_RD : ST_DONE;
               end else begin
                  i_in     = bot_w;
                  j_in     = right_w;
                  cbase_in = right_w;
                  bad_in   = !query_ok;
                  state_in = query_ok ? ST_Q_WALK : ST_DONE;
               end
            end
         end
         ST_ADD_RD: begin
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            // read data for this cell is back, write the updated sum
            ram_we   = 1'b1;
            state_in = ST_ADD_RD;
            if (j_up > CIW'(COLS)) begin
               i_in = i_up;
               j_in = cbase_ff;
               if (i_up > RIW'(ROWS)) begin
                  state_in = ST_DONE;
               end
            end else begin
               j_in = j_up;
            end
         end
         ST_Q_WALK: begin
            if ((i_ff != '0) && (j_ff != '0)) begin
               rd_pend_in = 1'b1;
               rd_neg_in  = (phase_ff == PH_ABOVE) || (phase_ff == PH_LEFT);
            end
            if ((i_ff != '0) && (j_ff != '0) && (j_dn != '0)) begin
               j_in = j_dn;
            end else if ((i_ff != '0) && (j_ff != '0) && (i_dn != '0)) begin
               i_in = i_dn;
               j_in = cbase_ff;
            end else if (phase_ff == PH_LAST) begin
               state_in = ST_Q_DRAIN;
            end else begin
               phase_in = ph_next;
               i_in     = ph_r;
               j_in     = ph_c;
               cbase_in = ph_c;
            end
         end
         ST_Q_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      cbase_ff  <= cbase_in;
      r1m1_ff   <= r1m1_in;
      r2_ff     <= r2_in;
      c1m1_ff   <= c1m1_in;
      c2_ff     <= c2_in;
      val_ff    <= val_in;
      acc_ff    <= acc_in;
      phase_ff  <= phase_in;
      rd_neg_ff <= rd_neg_in;
      bad_ff    <= bad_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign res_valid            = (state_ff == ST_DONE);
   assign res_data.rect_sum    = acc_ff;
   assign res_data.bad_request = bad_ff;

endmodule
